/* rtl/s3rp_pkg.sv */
package s3rp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROUNDS = 3;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t ROUND_K [ROUNDS] = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf};

  // Item flowing between round cells. Message words are used from slot 0 and
  // rotated; results enter at the top slot and shift down.
  typedef struct packed {
    logic                    valid;
    word_t                   a, b, c, d, e, f, g, h;
    word_t [ROUNDS-1:0]      w;
    word_t [ROUNDS-1:0]      na;
    word_t [ROUNDS-1:0]      ne;
  } work_t;

  // Inside a cell, after the sum stage.
  typedef struct packed {
    logic                    valid;
    word_t                   t1, t2;
    word_t                   a, b, c, d, e, f, g;
    word_t [ROUNDS-1:0]      w;
    word_t [ROUNDS-1:0]      na;
    word_t [ROUNDS-1:0]      ne;
  } mid_t;

  function automatic word_t big_sigma0(input word_t v);
    big_sigma0 = {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    big_sigma1 = {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    choose = g ^ ((f ^ g) & e);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    majority = ((a | b) & c) | (a & b);
  endfunction

endpackage

/* rtl/s3rp_round_cell.sv */
module s3rp_round_cell (
  input  logic           clk,
  input  logic           rst,
  input  s3rp_pkg::word_t k,
  input  s3rp_pkg::work_t din,
  output s3rp_pkg::work_t dout
);

  localparam int unsigned LAST = s3rp_pkg::ROUNDS - 1;

  s3rp_pkg::mid_t  mid, mid_next;
  s3rp_pkg::work_t dout_next;

  // stage 1: T1 and T2
  always_comb begin
    mid_next.valid = din.valid;
    mid_next.t1 = din.h + s3rp_pkg::big_sigma1(din.e) + s3rp_pkg::choose(din.e, din.f, din.g)
                  + k + din.w[0];
    mid_next.t2 = s3rp_pkg::big_sigma0(din.a) + s3rp_pkg::majority(din.a, din.b, din.c);
    mid_next.a  = din.a;
    mid_next.b  = din.b;
    mid_next.c  = din.c;
    mid_next.d  = din.d;
    mid_next.e  = din.e;
    mid_next.f  = din.f;
    mid_next.g  = din.g;
    mid_next.w  = din.w;
    mid_next.na = din.na;
    mid_next.ne = din.ne;
  end

  // stage 2: state update, result words shift down, message words rotate
  always_comb begin
    dout_next.valid = mid.valid;
    dout_next.a = mid.t1 + mid.t2;
    dout_next.b = mid.a;
    dout_next.c = mid.b;
    dout_next.d = mid.c;
    dout_next.e = mid.d + mid.t1;
    dout_next.f = mid.e;
    dout_next.g = mid.f;
    dout_next.h = mid.g;
    for (int i = 0; i < LAST; i++) begin
      dout_next.w[i]  = mid.w[i+1];
      dout_next.na[i] = mid.na[i+1];
      dout_next.ne[i] = mid.ne[i+1];
    end
    dout_next.w[LAST]  = mid.w[0];
    dout_next.na[LAST] = dout_next.a;
    dout_next.ne[LAST] = dout_next.e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid  <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      mid  <= mid_next;
      dout <= dout_next;
    end
  end

endmodule

/* rtl/sha256_three_round_precalc.sv */
// Three-round SHA-256 midstate precalculation.
//
// Command channel: a transfer happens at a rising edge with start high and
// busy low. The item is the midstate (state_a .. state_h) and the first
// three message words of the second block (msg_word0 .. msg_word2).
// busy is low except during reset, so a new item may follow every cycle.
//
// Result channel: done is high for exactly one cycle and the six words
// a_round1..3 and e_round1..3 (new a and e after rounds one to three) are
// valid in that cycle only. The receiver cannot stall; there is no backpressure.
//
// Structure: a row of three identical round cells, each two register stages
// deep (T1/T2 sums, then the state update). Results come from the state-update
// register of the third cell; throughput is one item per cycle outside reset, set
// by the cell stage, whose longest path is the five-operand T1 sum.
//
// Reset clears the valid bits in the row, so items in flight are dropped
// and no result is strobed until new items arrive. Nothing else is kept.
module sha256_three_round_precalc (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  s3rp_pkg::word_t  state_a,
  input  s3rp_pkg::word_t  state_b,
  input  s3rp_pkg::word_t  state_c,
  input  s3rp_pkg::word_t  state_d,
  input  s3rp_pkg::word_t  state_e,
  input  s3rp_pkg::word_t  state_f,
  input  s3rp_pkg::word_t  state_g,
  input  s3rp_pkg::word_t  state_h,
  input  s3rp_pkg::word_t  msg_word0,
  input  s3rp_pkg::word_t  msg_word1,
  input  s3rp_pkg::word_t  msg_word2,
  output logic             done,
  output s3rp_pkg::word_t  a_round1,
  output s3rp_pkg::word_t  a_round2,
  output s3rp_pkg::word_t  a_round3,
  output s3rp_pkg::word_t  e_round1,
  output s3rp_pkg::word_t  e_round2,
  output s3rp_pkg::word_t  e_round3
);

  localparam int unsigned NR = s3rp_pkg::ROUNDS;

  s3rp_pkg::work_t link [NR+1];

  assign busy = rst;

  // Head of the row: the incoming item, result slots zeroed.
  always_comb begin
    link[0].valid = start & ~busy;
    link[0].a = state_a;
    link[0].b = state_b;
    link[0].c = state_c;
    link[0].d = state_d;
    link[0].e = state_e;
    link[0].f = state_f;
    link[0].g = state_g;
    link[0].h = state_h;
    link[0].w[0] = msg_word0;
    link[0].w[1] = msg_word1;
    link[0].w[2] = msg_word2;
    link[0].na = '0;
    link[0].ne = '0;
  end

  for (genvar i = 0; i < NR; i++) begin : g_cell
    s3rp_round_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .k    (s3rp_pkg::ROUND_K[i]),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  // After the last cell, slot 0 holds round one, slot 2 round three.
  assign done     = link[NR].valid;
  assign a_round1 = link[NR].na[0];
  assign a_round2 = link[NR].na[1];
  assign a_round3 = link[NR].na[2];
  assign e_round1 = link[NR].ne[0];
  assign e_round2 = link[NR].ne[1];
  assign e_round3 = link[NR].ne[2];

  // Every transfer gives one strobe, and nothing else does.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, 6))
    else $error("result strobe does not match accepted items");

  // Round one: a1 - e1 = T2 - d.
  a_round1_rel: assert property (@(posedge clk) disable iff (rst)
    done |-> ((a_round1 - e_round1) ==
      $past(s3rp_pkg::big_sigma0(state_a) + s3rp_pkg::majority(state_a, state_b, state_c)
            - state_d, 6)))
    else $error("round one a/e words inconsistent");

  // Reset drops work in flight.
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  typedef s3rp_pkg::word_t word_t;

  // One command: midstate words a..h (st[0] = a) and message words for rounds 1..3.
  typedef struct packed {
    word_t [7:0] st;
    word_t [2:0] msg;
  } midstate_item_t;

  // One result: new a and new e after rounds 1..3 (index 0 = round one).
  typedef struct packed {
    word_t [2:0] na;
    word_t [2:0] ne;
  } round_words_t;

  localparam int unsigned IDLE_LIMIT = 500;  // gap is at most 18
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned TAIL_CYCLES = 12;

  // Checks results in order against the three rounds worked out for each
  // accepted transfer. The block keeps nothing between items, so the
  // prediction needs no state of its own.
  class round_scoreboard;
    localparam word_t K0 = 32'h428a2f98;
    localparam word_t K1 = 32'h71374491;
    localparam word_t K2 = 32'hb5c0fbcf;

    round_words_t expected_rounds[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    static function word_t ror(word_t v, int s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function round_words_t run_three_rounds(midstate_item_t it);
      word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1, ch, mj;
      word_t k [3];
      round_words_t res;
      k = '{K0, K1, K2};
      {a, b, c, d} = {it.st[0], it.st[1], it.st[2], it.st[3]};
      {e, f, g, h} = {it.st[4], it.st[5], it.st[6], it.st[7]};
      for (int r = 0; r < 3; r++) begin
        s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
        s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
        ch = (e & f) ^ (~e & g);
        mj = (a & b) ^ (a & c) ^ (b & c);
        // 32-bit sums wrap on their own
        t1 = h + s1 + ch + k[r] + it.msg[r];
        t2 = s0 + mj;
        h = g;
        g = f;
        f = e;
        e = d + t1;
        d = c;
        c = b;
        b = a;
        a = t1 + t2;
        res.na[r] = a;
        res.ne[r] = e;
      end
      return res;
    endfunction

    function void note_item(midstate_item_t it);
      expected_rounds.push_back(run_three_rounds(it));
    endfunction

    function void check_result(round_words_t got);
      round_words_t want;
      if (expected_rounds.size() == 0) begin
        $display("%0t: result with nothing pending: a %h %h %h, e %h %h %h", $time,
                 got.na[0], got.na[1], got.na[2], got.ne[0], got.ne[1], got.ne[2]);
        failures++;
        return;
      end
      want = expected_rounds.pop_front();
      for (int r = 0; r < 3; r++) begin
        if (got.na[r] !== want.na[r]) begin
          $display("%0t: a_round%0d expected %h, actual %h", $time, r + 1,
                   want.na[r], got.na[r]);
          failures++;
        end
        if (got.ne[r] !== want.ne[r]) begin
          $display("%0t: e_round%0d expected %h, actual %h", $time, r + 1,
                   want.ne[r], got.ne[r]);
          failures++;
        end
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  logic  done;
  word_t state_a = '0, state_b = '0, state_c = '0, state_d = '0;
  word_t state_e = '0, state_f = '0, state_g = '0, state_h = '0;
  word_t msg_word0 = '0, msg_word1 = '0, msg_word2 = '0;
  word_t a_round1, a_round2, a_round3, e_round1, e_round2, e_round3;

  round_scoreboard board;
  int unsigned idle_cycles = 0;

  sha256_three_round_precalc i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .state_a   (state_a),
    .state_b   (state_b),
    .state_c   (state_c),
    .state_d   (state_d),
    .state_e   (state_e),
    .state_f   (state_f),
    .state_g   (state_g),
    .state_h   (state_h),
    .msg_word0 (msg_word0),
    .msg_word1 (msg_word1),
    .msg_word2 (msg_word2),
    .done      (done),
    .a_round1  (a_round1),
    .a_round2  (a_round2),
    .a_round3  (a_round3),
    .e_round1  (e_round1),
    .e_round2  (e_round2),
    .e_round3  (e_round3)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Monitor and watchdog. Everything is driven with NBAs at the edge, so the
  // values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    midstate_item_t seen;
    round_words_t got;
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      // result first: it always belongs to an older transfer
      if (done === 1'b1) begin
        got.na = {a_round3, a_round2, a_round1};
        got.ne = {e_round3, e_round2, e_round1};
        board.check_result(got);
        moved = 1'b1;
      end
      if (start && busy === 1'b0) begin
        seen.st = {state_h, state_g, state_f, state_e, state_d, state_c, state_b, state_a};
        seen.msg = {msg_word2, msg_word1, msg_word0};
        board.note_item(seen);
        moved = 1'b1;
      end
    end
    if (moved) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly uniform words, with a share of corner patterns to hit carry chains
  // and the rotation boundaries.
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 31);
      3:       return ~(word_t'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Hold start low through the gap, then present the command and wait for the
  // transfer. Returns in the time step of the accepting edge with start
  // still high, so a back-to-back item never drops start.
  task automatic send_item(input midstate_item_t it, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    state_a   <= it.st[0];
    state_b   <= it.st[1];
    state_c   <= it.st[2];
    state_d   <= it.st[3];
    state_e   <= it.st[4];
    state_f   <= it.st[5];
    state_g   <= it.st[6];
    state_h   <= it.st[7];
    msg_word0 <= it.msg[0];
    msg_word1 <= it.msg[1];
    msg_word2 <= it.msg[2];
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Stop sending and let the pipeline empty out.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (board.expected_rounds.size() != 0) @(posedge clk);
  endtask

  initial begin
    midstate_item_t it;
    bit no_idle;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // all zero, all ones, alternating bits both ways
    it = '0;
    send_item(it, $urandom_range(0, 18));
    it = '1;
    send_item(it, $urandom_range(0, 18));
    it = {11{32'haaaaaaaa}};
    send_item(it, 0);
    it = {11{32'h55555555}};
    send_item(it, 0);
    // standard initial hash with the first message words of "abc"
    it.st = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
             32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};
    it.msg = {32'h00000000, 32'h00000000, 32'h61626380};
    send_item(it, $urandom_range(0, 18));
    // one word all ones, the rest zero: isolates each input's path
    for (int i = 0; i < 11; i++) begin
      it = '0;
      it[32*i +: 32] = '1;
      send_item(it, $urandom_range(0, 3));
    end
    // top bit only, low bit only, and all but the top bit in every word
    it = {11{32'h80000000}};
    send_item(it, 0);
    it = {11{32'h00000001}};
    send_item(it, $urandom_range(0, 18));
    it = {11{32'h7fffffff}};
    send_item(it, 0);

    // sender holds off until everything is back
    drain_pipeline();

    // --- random part, in bursts with and without gaps ---
    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) drain_pipeline();
      for (int i = 0; i < 8; i++) it.st[i] = rand_word();
      for (int i = 0; i < 3; i++) it.msg[i] = rand_word();
      send_item(it, no_idle ? 0 : $urandom_range(0, 18));
    end

    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.failures == 0 && board.expected_rounds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sha256_three_round_precalc.f */
rtl/s3rp_pkg.sv
rtl/s3rp_round_cell.sv
rtl/sha256_three_round_precalc.sv
tb/testbench.sv
